/* src/gpio_irq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_irq_pkg
// Shared types and constants of the 8-pin gpio group with interrupt detect.
// ----------------------------------------------------------------------------
package gpio_irq_pkg;

   localparam int PinCount = 8;
   localparam logic [7:0] PinMask = 8'((1 << PinCount) - 1);

   typedef enum logic [1:0] {
      KIND_IDLE  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_RSVD  = 2'd3
   } kind_type;

   localparam logic [11:0] OfsDir     = 12'h400;
   localparam logic [11:0] OfsIs      = 12'h404;
   localparam logic [11:0] OfsIbe     = 12'h408;
   localparam logic [11:0] OfsIev     = 12'h40C;
   localparam logic [11:0] OfsIe      = 12'h410;
   localparam logic [11:0] OfsRis     = 12'h414;
   localparam logic [11:0] OfsMis     = 12'h418;
   localparam logic [11:0] OfsIc      = 12'h41C;
   localparam logic [11:0] OfsAfsel   = 12'h420;
   localparam logic [11:0] OfsDataEnd = 12'h3FC;

   typedef struct packed {
      logic [7:0] dir;
      logic [7:0] data;
      logic [7:0] sense;
      logic [7:0] both;
      logic [7:0] polarity;
      logic [7:0] enable;
      logic [7:0] alt;
   } cfg_type;

endpackage

/* src/gpio_irq_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_irq_regs
// Bus register file: decodes one access, returns read data and the
// next register values, and hands interrupt clear bits to the detector.
// ----------------------------------------------------------------------------
module gpio_irq_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [1:0]            kind,
   input  logic [11:0]           reg_offset,
   input  logic [7:0]            write_value,
   input  logic [7:0]            pads,
   input  logic [7:0]            raw_status,
   output gpio_irq_pkg::cfg_type cfg_ff,
   output gpio_irq_pkg::cfg_type cfg_in,
   output logic [7:0]            clear,
   output logic [7:0]            read_value
);
   import gpio_irq_pkg::*;

   logic [11:0] ofs;
   logic [7:0]  sel;
   logic [7:0]  wval;
   logic [7:0]  pins;

   assign ofs  = {reg_offset[11:2], 2'b00};
   assign sel  = ofs[9:2] & PinMask;
   assign wval = write_value & PinMask;
   assign pins = (cfg_ff.data & cfg_ff.dir) | (pads & ~cfg_ff.dir);

   // read returns values from before this item
   always_comb begin
      read_value = '0;
      if (kind_type'(kind) == KIND_READ) begin
         if (ofs <= OfsDataEnd) begin
            read_value = pins & sel & PinMask;
         end else begin
            case (ofs)
               OfsDir:   read_value = cfg_ff.dir;
               OfsIs:    read_value = cfg_ff.sense;
               OfsIbe:   read_value = cfg_ff.both;
               OfsIev:   read_value = cfg_ff.polarity;
               OfsIe:    read_value = cfg_ff.enable;
               OfsRis:   read_value = raw_status;
               OfsMis:   read_value = raw_status & cfg_ff.enable;
               OfsAfsel: read_value = cfg_ff.alt;
               default:  read_value = '0;
            endcase
         end
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      clear  = '0;
      if (kind_type'(kind) == KIND_WRITE) begin
         if (ofs <= OfsDataEnd) begin
            cfg_in.data = (cfg_ff.data & ~sel) | (wval & sel);
         end else begin
            case (ofs)
               OfsDir:   cfg_in.dir      = wval;
               OfsIs:    cfg_in.sense    = wval;
               OfsIbe:   cfg_in.both     = wval;
               OfsIev:   cfg_in.polarity = wval;
               OfsIe:    cfg_in.enable   = wval;
               OfsAfsel: cfg_in.alt      = wval;
               OfsIc:    clear           = wval;
               default:  clear           = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (advance) begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/gpio_irq_detect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_irq_detect
// Per-pin level and edge detection with latched raw status and the
// pad levels of the previous item.
// ----------------------------------------------------------------------------
module gpio_irq_detect (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            pads,
   input  gpio_irq_pkg::cfg_type cfg,
   input  logic [7:0]            clear,
   output logic [7:0]            raw_ff,
   output logic [7:0]            raw_in,
   output logic [7:0]            prev_pads_ff
);
   import gpio_irq_pkg::*;

   logic [7:0] rise;
   logic [7:0] fall;
   logic [7:0] edge_hit;
   logic [7:0] level_hit;
   logic [7:0] edge_part;

   always_comb begin
      rise      = pads & ~prev_pads_ff;
      fall      = ~pads & prev_pads_ff;
      edge_hit  = ((cfg.both & (rise | fall)) |
                   (~cfg.both & ((cfg.polarity & rise) | (~cfg.polarity & fall))))
                  & ~cfg.sense;
      level_hit = cfg.sense & ~(pads ^ cfg.polarity);
      // edge wins over a clear in the same item
      edge_part = ((raw_ff & ~clear) | edge_hit) & ~cfg.sense;
      raw_in    = (edge_part | level_hit) & PinMask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff       <= '0;
         prev_pads_ff <= '0;
      end else if (advance) begin
         raw_ff       <= raw_in;
         prev_pads_ff <= pads;
      end
   end

endmodule

/* src/gpio_port_with_irq_detect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_port_with_irq_detect
// Top level of the 8-pin gpio group with interrupt detection.
// ----------------------------------------------------------------------------
// One item is one bus access (idle, read or write) plus the pad levels of that
// cycle, and it gives exactly one result. An item is captured in an input
// register, then decoded and applied to the registers and interrupt detector
// when the result register can take it, and its result is loaded into the
// result register at that edge. A new item is taken every cycle as long as
// the result side keeps rsp_ready high; the result register is the only stage
// that can hold back the input side.
// ----------------------------------------------------------------------------
module gpio_port_with_irq_detect (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [11:0] req_reg_offset,
   input  logic [7:0] req_write_value,
   input  logic [7:0] req_pad_levels,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_value,
   output logic [7:0] rsp_pad_drive,
   output logic [7:0] rsp_pad_output_enable,
   output logic       rsp_irq_out
);
   import gpio_irq_pkg::*;

   logic        in_valid_ff;
   logic [1:0]  in_kind_ff;
   logic [11:0] in_offset_ff;
   logic [7:0]  in_wval_ff;
   logic [7:0]  in_pads_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_read_ff;
   logic [7:0]  rsp_drive_ff;
   logic [7:0]  rsp_oe_ff;
   logic        rsp_irq_ff;

   logic        advance;
   logic [7:0]  pads;
   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [7:0]  clear;
   logic [7:0]  read_value;
   logic [7:0]  raw_ff;
   logic [7:0]  raw_in;
   logic [7:0]  prev_pads_ff;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign pads      = in_pads_ff & PinMask;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff   <= req_kind;
         in_offset_ff <= req_reg_offset;
         in_wval_ff   <= req_write_value;
         in_pads_ff   <= req_pad_levels;
      end
   end

   gpio_irq_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .kind        (in_kind_ff),
      .reg_offset  (in_offset_ff),
      .write_value (in_wval_ff),
      .pads        (pads),
      .raw_status  (raw_ff),
      .cfg_ff      (cfg_ff),
      .cfg_in      (cfg_in),
      .clear       (clear),
      .read_value  (read_value)
   );

   gpio_irq_detect u_detect (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .pads         (pads),
      .cfg          (cfg_in),
      .clear        (clear),
      .raw_ff       (raw_ff),
      .raw_in       (raw_in),
      .prev_pads_ff (prev_pads_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_read_ff  <= '0;
         rsp_drive_ff <= '0;
         rsp_oe_ff    <= '0;
         rsp_irq_ff   <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            rsp_read_ff  <= read_value;
            rsp_drive_ff <= cfg_in.data & ~cfg_in.alt & PinMask;
            rsp_oe_ff    <= cfg_in.dir & ~cfg_in.alt & PinMask;
            rsp_irq_ff   <= |(raw_in & cfg_in.enable);
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_value        = rsp_read_ff;
   assign rsp_pad_drive         = rsp_drive_ff;
   assign rsp_pad_output_enable = rsp_oe_ff;
   assign rsp_irq_out           = rsp_irq_ff;

   // irq line matches the stored status and enable
   assert property (@(posedge clock) disable iff (reset)
      rsp_irq_ff == (|(raw_ff & cfg_ff.enable)))
      else $error("irq line out of step with masked status");

   // level pins track the previous pad level
   assert property (@(posedge clock) disable iff (reset)
      (raw_ff & cfg_ff.sense) == (cfg_ff.sense & ~(prev_pads_ff ^ cfg_ff.polarity)))
      else $error("level status does not follow pad");

   // only reads give read data
   assert property (@(posedge clock) disable iff (reset)
      advance && (kind_type'(in_kind_ff) != KIND_READ) |=> rsp_read_ff == '0)
      else $error("read data on a non-read item");

   // output enable follows the stored dir and alt registers
   assert property (@(posedge clock) disable iff (reset)
      rsp_oe_ff == (cfg_ff.dir & ~cfg_ff.alt))
      else $error("output enable out of step with registers");

endmodule
